// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the top-level RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Assertion sampled on the rising clock edge and disabled while reset is low.
`define IPID_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion sampled on the rising clock edge, also checked during reset.
`define IPID_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPID_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define IPID_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ----- design/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// Incremental PID package
// Widths, codes, control word layout and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ERR_W      = 32;
  localparam int GAIN_W     = 24;
  localparam int OPT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = ERR_W + 3 * GAIN_W;
  localparam int OUT_TDATA_W = ERR_W;

  // Second difference e0 - 2*e1 + e2 is given three guard bits.
  localparam int D2_W    = ERR_W + 3;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;
  localparam int MAG_W   = PROD_W - 1;
  localparam int SH_W    = MUL_A_W;
  localparam int SHF_W   = ACC_W - FRAC_BITS;

  localparam int DIV_STEPS = 2;
  localparam int DIV_ITERS = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = '0;

  localparam logic [GAIN_W-1:0] TS_RESET = GAIN_W'(24'h01_0000);

  // Integer part of the sum is clamped to +/- 2^33 before the gain multiply.
  localparam logic signed [SHF_W-1:0] SH_MAX = SHF_W'(64'h0000_0002_0000_0000);
  localparam logic signed [SHF_W-1:0] SH_MIN = -SH_MAX;

  localparam logic [ERR_W-1:0] INC_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic [ERR_W-1:0] INC_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  typedef enum logic [OPT_W-1:0] {
    OPT_PID = 2'd0,
    OPT_P   = 2'd1,
    OPT_PI  = 2'd2,
    OPT_PD  = 2'd3
  } ctrl_opt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTROL_OPTION = 1'b0,
    CFG_SAMPLE_PERIOD  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_DIFF,
    ACC_ADDQ,
    ACC_SHPROD,
    ACC_ADDPROD
  } acc_op_e;

  typedef enum logic [2:0] {
    MUL_NOP,
    MUL_E_TS,
    MUL_D2_TD,
    MUL_KP_SL,
    MUL_KP_SH
  } mul_op_e;

  typedef enum logic {
    DEN_TI,
    DEN_TS
  } den_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_GO,
    COND_SKIP_I,
    COND_SKIP_D,
    COND_DIV_BUSY,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    acc_op_e            acc_op;
    mul_op_e            mul_op;
    logic               ld_sh;
    logic               div_go;
    den_sel_e           den;
    logic               emit;
    cond_e              cond;
    logic [STEP_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic go;
    logic skip_i;
    logic skip_d;
    logic div_busy;
    logic out_blocked;
  } stat_t;

  localparam uword_t UWORD_NOP = '{
    acc_op: ACC_NOP, mul_op: MUL_NOP, ld_sh: 1'b0, div_go: 1'b0,
    den: DEN_TI, emit: 1'b0, cond: COND_NEVER, target: STEP_IDLE
  };

  // The control program. A step falls through to the next one unless its
  // condition holds, in which case it goes to its target.
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = UWORD_NOP;
    unique case (step)
      4'd0: begin
        w.cond = COND_NOT_GO;   w.target = 4'd0;
      end
      4'd1: begin
        w.acc_op = ACC_DIFF;
        w.cond = COND_SKIP_I;   w.target = 4'd6;
      end
      4'd2: w.mul_op = MUL_E_TS;
      4'd3: begin
        w.div_go = 1'b1;        w.den = DEN_TI;
      end
      4'd4: begin
        w.cond = COND_DIV_BUSY; w.target = 4'd4;
      end
      4'd5: w.acc_op = ACC_ADDQ;
      4'd6: begin
        w.cond = COND_SKIP_D;   w.target = 4'd11;
      end
      4'd7: w.mul_op = MUL_D2_TD;
      4'd8: begin
        w.div_go = 1'b1;        w.den = DEN_TS;
      end
      4'd9: begin
        w.cond = COND_DIV_BUSY; w.target = 4'd9;
      end
      4'd10: w.acc_op = ACC_ADDQ;
      4'd11: begin
        w.mul_op = MUL_KP_SL;   w.ld_sh = 1'b1;
      end
      4'd12: begin
        w.acc_op = ACC_SHPROD;  w.mul_op = MUL_KP_SH;
      end
      4'd13: w.acc_op = ACC_ADDPROD;
      4'd14: begin
        w.cond = COND_OUT_BLOCKED; w.target = 4'd14;
      end
      4'd15: begin
        w.emit = 1'b1;
        w.cond = COND_ALWAYS;   w.target = STEP_IDLE;
      end
      default: w = UWORD_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- design/ipid_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Signed dividend by positive divisor, quotient rounded toward minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_div (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [ipid_pkg::PROD_W-1:0]   num_i,
  input  wire logic        [ipid_pkg::GAIN_W-1:0]   den_i,
  output logic                                      busy_o,
  output logic signed      [ipid_pkg::ACC_W-1:0]    quot_o
);

  logic                               busy_q, busy_d;
  logic                               fin_q, fin_d;
  logic [ipid_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               neg_q;
  logic [ipid_pkg::MAG_W-1:0]         mag_q, mag_n;
  logic [ipid_pkg::GAIN_W-1:0]        rem_q, rem_n;
  logic [ipid_pkg::GAIN_W-1:0]        den_q;
  logic signed [ipid_pkg::ACC_W-1:0]  quot_q;
  logic [ipid_pkg::PROD_W-1:0]        num_abs;
  logic [ipid_pkg::ACC_W-1:0]         mag_ext;

  assign num_abs = num_i[ipid_pkg::PROD_W-1] ? -num_i : num_i;
  assign mag_ext = {1'b0, mag_q};

  // Restoring division, DIV_STEPS quotient bits per cycle.
  always_comb begin
    logic [ipid_pkg::GAIN_W:0]   trial;
    logic [ipid_pkg::GAIN_W-1:0] rem_v;
    logic [ipid_pkg::MAG_W-1:0]  mag_v;
    trial = '0;
    rem_v = rem_q;
    mag_v = mag_q;
    for (int i = 0; i < ipid_pkg::DIV_STEPS; i++) begin
      trial = {rem_v, mag_v[ipid_pkg::MAG_W-1]};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        mag_v = {mag_v[ipid_pkg::MAG_W-2:0], 1'b1};
      end else begin
        mag_v = {mag_v[ipid_pkg::MAG_W-2:0], 1'b0};
      end
      rem_v = trial[ipid_pkg::GAIN_W-1:0];
    end
    mag_n = mag_v;
    rem_n = rem_v;
  end

  always_comb begin
    busy_d = busy_q;
    fin_d  = fin_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      fin_d  = 1'b0;
      cnt_d  = ipid_pkg::DIV_CNT_W'(ipid_pkg::DIV_ITERS);
    end else if (busy_q && !fin_q) begin
      cnt_d = cnt_q - ipid_pkg::DIV_CNT_W'(1);
      if (cnt_q == ipid_pkg::DIV_CNT_W'(1)) begin
        fin_d = 1'b1;
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
      fin_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[ipid_pkg::PROD_W-1];
      mag_q <= num_abs[ipid_pkg::MAG_W-1:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && !fin_q) begin
      mag_q <= mag_n;
      rem_q <= rem_n;
    end else if (busy_q) begin
      // A negative dividend with a remainder rounds one further down: ~m.
      if (!neg_q) begin
        quot_q <= $signed(mag_ext);
      end else if (rem_q != '0) begin
        quot_q <= $signed(~mag_ext);
      end else begin
        quot_q <= $signed(-mag_ext);
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- design/ipid_dpath.sv -----
// ----------------------------------------------------------------------------
// Incremental PID datapath
// Error history, shared multiplier, accumulator, divider and output clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                load_i,
  input  wire logic        [ipid_pkg::ERR_W-1:0]   error_now_i,
  input  wire logic        [ipid_pkg::GAIN_W-1:0]  gain_kp_i,
  input  wire logic        [ipid_pkg::GAIN_W-1:0]  integral_time_i,
  input  wire logic        [ipid_pkg::GAIN_W-1:0]  derivative_time_i,
  input  wire ipid_pkg::ctrl_opt_e                 ctrl_opt_i,
  input  wire logic        [ipid_pkg::GAIN_W-1:0]  sample_period_i,
  input  wire ipid_pkg::uword_t                    uword_i,
  output logic                                     skip_i_o,
  output logic                                     skip_d_o,
  output logic                                     div_busy_o,
  output logic             [ipid_pkg::ERR_W-1:0]   increment_o,
  output logic                                     saturated_o
);

  logic signed [ipid_pkg::ERR_W-1:0]   e2_q, e1_q, e0_q;
  logic        [ipid_pkg::GAIN_W-1:0]  kp_q, ti_q, td_q;
  logic signed [ipid_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic signed [ipid_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic signed [ipid_pkg::SH_W-1:0]    sh_q, sh_d;
  logic signed [ipid_pkg::D2_W-1:0]    d2;
  logic signed [ipid_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ipid_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ipid_pkg::SHF_W-1:0]   shf;
  logic signed [ipid_pkg::ACC_W-1:0]   quot;
  logic        [ipid_pkg::GAIN_W-1:0]  den;
  logic        [ipid_pkg::ACC_W-ipid_pkg::ERR_W:0] hi_bits;
  logic                                use_i, use_d;

  assign use_i = (ctrl_opt_i == ipid_pkg::OPT_PID) ||
                 (ctrl_opt_i == ipid_pkg::OPT_PI);
  assign use_d = (ctrl_opt_i == ipid_pkg::OPT_PID) ||
                 (ctrl_opt_i == ipid_pkg::OPT_PD);
  assign skip_i_o = !use_i || (ti_q == '0);
  assign skip_d_o = !use_d || (sample_period_i == '0);

  assign d2 = ipid_pkg::D2_W'(e0_q) + ipid_pkg::D2_W'(e2_q) - (ipid_pkg::D2_W'(e1_q) <<< 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uword_i.mul_op)
      ipid_pkg::MUL_E_TS: begin
        mul_a = ipid_pkg::MUL_A_W'(e2_q);
        mul_b = $signed({1'b0, sample_period_i});
      end
      ipid_pkg::MUL_D2_TD: begin
        mul_a = ipid_pkg::MUL_A_W'(d2);
        mul_b = $signed({1'b0, td_q});
      end
      ipid_pkg::MUL_KP_SL: begin
        mul_a = $signed({{(ipid_pkg::MUL_A_W-ipid_pkg::FRAC_BITS){1'b0}},
                         acc_q[ipid_pkg::FRAC_BITS-1:0]});
        mul_b = $signed({1'b0, kp_q});
      end
      ipid_pkg::MUL_KP_SH: begin
        mul_a = sh_q;
        mul_b = $signed({1'b0, kp_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Integer part of the sum, clamped before it meets the gain.
  assign shf = acc_q[ipid_pkg::ACC_W-1:ipid_pkg::FRAC_BITS];
  always_comb begin
    if (shf > ipid_pkg::SH_MAX) begin
      sh_d = ipid_pkg::SH_MAX[ipid_pkg::SH_W-1:0];
    end else if (shf < ipid_pkg::SH_MIN) begin
      sh_d = ipid_pkg::SH_MIN[ipid_pkg::SH_W-1:0];
    end else begin
      sh_d = shf[ipid_pkg::SH_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    case (uword_i.acc_op)
      ipid_pkg::ACC_DIFF:    acc_d = ipid_pkg::ACC_W'(e2_q) - ipid_pkg::ACC_W'(e1_q);
      ipid_pkg::ACC_ADDQ:    acc_d = acc_q + quot;
      ipid_pkg::ACC_SHPROD:  acc_d = prod_q >>> ipid_pkg::FRAC_BITS;
      ipid_pkg::ACC_ADDPROD: acc_d = acc_q + prod_q;
      default:               acc_d = acc_q;
    endcase
  end

  assign den = (uword_i.den == ipid_pkg::DEN_TI) ? ti_q : sample_period_i;

  ipid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (uword_i.div_go),
    .num_i   (prod_q),
    .den_i   (den),
    .busy_o  (div_busy_o),
    .quot_o  (quot)
  );

  // History e1/e0 resets to zero; the working registers, e2 among them, carry no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      e0_q <= '0;
    end else if (uword_i.emit) begin
      e1_q <= e2_q;
      e0_q <= e1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e2_q <= $signed(error_now_i);
      kp_q <= gain_kp_i;
      ti_q <= integral_time_i;
      td_q <= derivative_time_i;
    end
    if (uword_i.mul_op != ipid_pkg::MUL_NOP) begin
      prod_q <= prod_d;
    end
    if (uword_i.ld_sh) begin
      sh_q <= sh_d;
    end
    acc_q <= acc_d;
  end

  // The result fits when the sign bit of the output and all bits above it agree.
  assign hi_bits     = acc_q[ipid_pkg::ACC_W-1:ipid_pkg::ERR_W-1];
  assign saturated_o = !((&hi_bits) || (~|hi_bits));
  assign increment_o = saturated_o ?
                       (acc_q[ipid_pkg::ACC_W-1] ? ipid_pkg::INC_MIN : ipid_pkg::INC_MAX) :
                       acc_q[ipid_pkg::ERR_W-1:0];

endmodule

`default_nettype wire

// ----- design/ipid_useq.sv -----
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_useq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ipid_pkg::stat_t    stat_i,
  output ipid_pkg::uword_t        uword_o,
  output logic                    idle_o
);

  logic [ipid_pkg::STEP_W-1:0] step_q, step_d;
  ipid_pkg::uword_t            word;
  logic                        take;

  assign word = ipid_pkg::ucode(step_q);

  always_comb begin
    unique case (word.cond)
      ipid_pkg::COND_NEVER:       take = 1'b0;
      ipid_pkg::COND_ALWAYS:      take = 1'b1;
      ipid_pkg::COND_NOT_GO:      take = !stat_i.go;
      ipid_pkg::COND_SKIP_I:      take = stat_i.skip_i;
      ipid_pkg::COND_SKIP_D:      take = stat_i.skip_d;
      ipid_pkg::COND_DIV_BUSY:    take = stat_i.div_busy;
      ipid_pkg::COND_OUT_BLOCKED: take = stat_i.out_blocked;
      default:                    take = 1'b0;
    endcase
    step_d = take ? word.target : step_q + ipid_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ipid_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign uword_o = word;
  assign idle_o  = (step_q == ipid_pkg::STEP_IDLE);

endmodule

`default_nettype wire

// ----- design/incremental_pid_controller_top.sv -----
// ----------------------------------------------------------------------------
// Incremental PID controller, top level
// Input beat to output beat: the integral and derivative terms each add a divide,
// and each divide holds the step counter while the divider is busy.
// One item at a time: the next input beat is taken once the result has entered
// the output register, so a new item never starts before the last one is done.
// Reset clears the history, output valid and sequencer; options go to PID, Ts 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module incremental_pid_controller_top (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // Configuration write port.
  input  wire logic                                    cfg_we_i,
  input  wire logic [ipid_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [ipid_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // Input stream.
  input  wire logic                                    s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // tdata: error_now[31:0], gain_kp[55:32], integral_time[79:56],
  //        derivative_time[103:80]
  input  wire logic [ipid_pkg::IN_TDATA_W-1:0]         s_axis_tdata_i,
  // Output stream.
  output logic                                         m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i,
  // tdata: increment[31:0]
  output logic [ipid_pkg::OUT_TDATA_W-1:0]             m_axis_tdata_o,
  // tuser: saturated[0]
  output logic                                         m_axis_tuser_o
);

  localparam int KP_LO = ipid_pkg::ERR_W;
  localparam int TI_LO = KP_LO + ipid_pkg::GAIN_W;
  localparam int TD_LO = TI_LO + ipid_pkg::GAIN_W;

  // Configuration registers. They are to be written only while the block is idle; the block does not enforce it.
  ipid_pkg::ctrl_opt_e               opt_q;
  logic [ipid_pkg::GAIN_W-1:0]       ts_q;

  // Output register: one finished result can wait here while the next
  // item is already being worked on.
  logic                              out_valid_q;
  logic [ipid_pkg::ERR_W-1:0]        out_inc_q;
  logic                              out_sat_q;

  ipid_pkg::uword_t                  uword;
  ipid_pkg::stat_t                   stat;
  logic                              idle;
  logic                              in_beat;
  logic                              skip_i, skip_d, div_busy;
  logic [ipid_pkg::ERR_W-1:0]        res_inc;
  logic                              res_sat;

  assign s_axis_tready_o = idle;
  assign in_beat         = s_axis_tvalid_i && idle;

  always_comb begin
    stat.go          = in_beat;
    stat.skip_i      = skip_i;
    stat.skip_d      = skip_d;
    stat.div_busy    = div_busy;
    stat.out_blocked = out_valid_q && !m_axis_tready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_q <= ipid_pkg::OPT_PID;
      ts_q  <= ipid_pkg::TS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipid_pkg::CFG_CONTROL_OPTION:
          opt_q <= ipid_pkg::ctrl_opt_e'(cfg_data_i[ipid_pkg::OPT_W-1:0]);
        ipid_pkg::CFG_SAMPLE_PERIOD:
          ts_q <= cfg_data_i[ipid_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer walks the control program once per item.
  ipid_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .uword_o (uword),
    .idle_o  (idle)
  );

  ipid_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (in_beat),
    .error_now_i       (s_axis_tdata_i[ipid_pkg::ERR_W-1:0]),
    .gain_kp_i         (s_axis_tdata_i[TI_LO-1:KP_LO]),
    .integral_time_i   (s_axis_tdata_i[TD_LO-1:TI_LO]),
    .derivative_time_i (s_axis_tdata_i[ipid_pkg::IN_TDATA_W-1:TD_LO]),
    .ctrl_opt_i        (opt_q),
    .sample_period_i   (ts_q),
    .uword_i           (uword),
    .skip_i_o          (skip_i),
    .skip_d_o          (skip_d),
    .div_busy_o        (div_busy),
    .increment_o       (res_inc),
    .saturated_o       (res_sat)
  );

  // The emit step runs only once the output register is free or being
  // drained in the same cycle, so no result is ever overwritten.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uword.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uword.emit) begin
      out_inc_q <= res_inc;
      out_sat_q <= res_sat;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_inc_q;
  assign m_axis_tuser_o  = out_sat_q;

  `IPID_ASSERT_RST(a_emit_free, clk_i, rst_ni, uword.emit |-> !stat.out_blocked,
    "emit while output register is held")
  `IPID_ASSERT_RST(a_div_no_restart, clk_i, rst_ni, uword.div_go |-> !div_busy,
    "divider started while busy")
  `IPID_ASSERT_RST(a_busy_after_beat, clk_i, rst_ni, in_beat |=> !s_axis_tready_o,
    "sequencer idle right after an input beat")
  `IPID_ASSERT_RST(a_sat_clip, clk_i, rst_ni,
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o == ipid_pkg::INC_MAX || m_axis_tdata_o == ipid_pkg::INC_MIN),
    "saturated result is not a range limit")
  `IPID_ASSERT_NORST(a_idle_div_quiet, clk_i, s_axis_tready_o |-> !div_busy,
    "divider busy while sequencer idle")

endmodule

`default_nettype wire
